### rtl/fbq_pkg.sv
// Package for the three-level feedback queue scheduler.
// Holds the transaction structs, the job record, operation codes and sequencer states.
// No dependencies; used by fbq_qptr, the top level and the testbench.
`default_nettype none

package fbq_pkg;

    // Default sizes handed to the top level.
    localparam int MAX_JOBS_DEF  = 16;
    localparam int MAX_TICKS_DEF = 16;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_BOOST = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_QUANTUM_L1 = 2'd0;
    localparam logic [1:0] CFG_QUANTUM_L2 = 2'd1;

    // Queue level numbers as held in the job store (level one is zero).
    localparam logic [1:0] LVL_ONE   = 2'd0;
    localparam logic [1:0] LVL_TWO   = 2'd1;
    localparam logic [1:0] LVL_THREE = 2'd2;

    // Reset values of the quanta.
    localparam logic [15:0] QUANTUM_L1_RST = 16'd2;
    localparam logic [15:0] QUANTUM_L2_RST = 16'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] job_id;
        logic [15:0] burst_time;
        logic [4:0]  tick_count;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [4:0]  boosted_count;
        logic        running_valid;
        logic [15:0] running_id;
        logic [1:0]  running_level;
        logic        finished_valid;
        logic [15:0] finished_id;
        logic [31:0] finish_time;
        logic [31:0] turnaround;
        logic [31:0] waiting_time;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [15:0] used;
        logic [31:0] arrival;
    } job_t;

    // One push and one pop request to the queue pointer unit.
    typedef struct packed {
        logic       push_en;
        logic [1:0] push_lvl;
        logic       pop_en;
        logic [1:0] pop_lvl;
    } qop_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEL,
        ST_LOAD,
        ST_RUN,
        ST_BRD,
        ST_BWR,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

### rtl/fbq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module fbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/fbq_qptr.sv
// Head pointers and fill counts of the three circular job queues.
// Depends on fbq_pkg for the push and pop request struct.
`default_nettype none

module fbq_qptr #(
    parameter int MAX_JOBS = fbq_pkg::MAX_JOBS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire fbq_pkg::qop_t                           qop,
    output logic [2:0][$clog2(MAX_JOBS+1)-1:0]           cnt,
    output logic [2:0][$clog2(MAX_JOBS)-1:0]             head,
    output logic [2:0][$clog2(MAX_JOBS)-1:0]             tail
);

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [2:0][IW-1:0] head_reg, head_next;
    logic [2:0][CW-1:0] cnt_reg, cnt_next;
    logic [2:0][IW:0]   tail_sum;

    // Tail slot is head plus count, wrapped once around the ring.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            tail_sum[l] = (IW+1)'(head_reg[l]) + (IW+1)'(cnt_reg[l]);
            if (tail_sum[l] >= (IW+1)'(MAX_JOBS)) begin
                tail[l] = IW'(tail_sum[l] - (IW+1)'(MAX_JOBS));
            end else begin
                tail[l] = IW'(tail_sum[l]);
            end
        end
    end

    // Pointer and count updates for one push and one pop.
    always_comb begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        if (qop.push_en) begin
            cnt_next[qop.push_lvl] = cnt_reg[qop.push_lvl] + CW'(1);
        end
        if (qop.pop_en) begin
            cnt_next[qop.pop_lvl] = cnt_reg[qop.pop_lvl] - CW'(1);
            if (head_reg[qop.pop_lvl] == IW'(MAX_JOBS - 1)) begin
                head_next[qop.pop_lvl] = '0;
            end else begin
                head_next[qop.pop_lvl] = head_reg[qop.pop_lvl] + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign cnt  = cnt_reg;
    assign head = head_reg;

    // A push and a pop in one cycle always address different queues.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (qop.push_en && qop.pop_en) |-> (qop.push_lvl != qop.pop_lvl))
        else $error("push and pop on the same queue");

endmodule

`default_nettype wire

### rtl/three_level_feedback_queue_scheduler_top.sv
// Top level of the three-level feedback queue scheduler: sequencer, running job and result register.
// Depends on fbq_pkg, fbq_ram (job store) and fbq_qptr (queue pointers).
//
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_data  (in_item_t: op, job, burst, ticks)
// m_        out        m_valid/m_ready    m_data  (out_item_t: one per advance time unit, else one per transaction)
// cfg_      in         cfg_valid/ready    cfg_index, cfg_data (quanta)
//
// An add or an unused op goes straight to hand-over; a boost alternates read and write per moved job.
// Each time unit of an advance steps through evaluate, select, optional load from the job store
// (registered read), run and hand to the result register.
// Reset is synchronous; queues come up empty, no job running, clock at zero.
// A stalled result register holds the sequencer in its hand-over state.
`default_nettype none

module three_level_feedback_queue_scheduler_top #(
    parameter int MAX_JOBS  = fbq_pkg::MAX_JOBS_DEF,
    parameter int MAX_TICKS = fbq_pkg::MAX_TICKS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fbq_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fbq_pkg::out_item_t      m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int AW = IW + 2;
    localparam int TW = $clog2(MAX_TICKS + 1);
    localparam int JW = $bits(fbq_pkg::job_t);

    fbq_pkg::state_t    state_reg, state_next;
    fbq_pkg::job_t      run_job_reg, run_job_next;
    logic               run_vld_reg, run_vld_next;
    logic [1:0]         cur_lvl_reg, cur_lvl_next;
    logic [31:0]        clk_cnt_reg, clk_cnt_next;
    logic [15:0]        quantum_l1_reg, quantum_l2_reg;
    logic [TW-1:0]      ticks_reg, ticks_next;
    logic [4:0]         moved_reg, moved_next;
    fbq_pkg::out_item_t res_reg, res_next;
    logic               m_valid_reg;
    fbq_pkg::out_item_t m_data_reg;

    fbq_pkg::qop_t      qop;
    logic [2:0][CW-1:0] cnt;
    logic [2:0][IW-1:0] head;
    logic [2:0][IW-1:0] tail;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    fbq_pkg::job_t      ram_wdata;
    logic [JW-1:0]      ram_rdata;
    fbq_pkg::job_t      rd_job;

    logic [CW+1:0]      total;
    logic [31:0]        ta;
    logic               s_fire;
    logic               out_free;

    fbq_ram #(
        .WIDTH (JW),
        .DEPTH (3 * (2 ** IW))
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fbq_qptr #(
        .MAX_JOBS (MAX_JOBS)
    ) u_qptr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .qop     (qop),
        .cnt     (cnt),
        .head    (head),
        .tail    (tail)
    );

    assign rd_job    = fbq_pkg::job_t'(ram_rdata);
    assign s_ready   = (state_reg == fbq_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Jobs held anywhere in the block, and turnaround of the running job.
    assign total = (CW+2)'(cnt[0]) + (CW+2)'(cnt[1]) + (CW+2)'(cnt[2])
                 + (CW+2)'(run_vld_reg);
    assign ta    = clk_cnt_reg - run_job_reg.arrival;

    // Sequencer: next state, job store accesses and queue requests.
    always_comb begin
        state_next   = state_reg;
        run_job_next = run_job_reg;
        run_vld_next = run_vld_reg;
        cur_lvl_next = cur_lvl_reg;
        clk_cnt_next = clk_cnt_reg;
        ticks_next   = ticks_reg;
        moved_next   = moved_reg;
        res_next     = res_reg;
        qop          = '0;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = run_job_reg;
        ram_raddr    = '0;

        case (state_reg)
            fbq_pkg::ST_IDLE: begin
                if (s_fire) begin
                    res_next      = '0;
                    res_next.last = 1'b1;
                    state_next    = fbq_pkg::ST_EMIT;
                    case (s_data.op)
                        fbq_pkg::OP_ADD: begin
                            if (s_data.burst_time != 16'd0
                                && total < (CW+2)'(MAX_JOBS)) begin
                                ram_we            = 1'b1;
                                ram_waddr         = {fbq_pkg::LVL_ONE, tail[0]};
                                ram_wdata.id        = s_data.job_id;
                                ram_wdata.burst     = s_data.burst_time;
                                ram_wdata.remaining = s_data.burst_time;
                                ram_wdata.used      = 16'd0;
                                ram_wdata.arrival   = clk_cnt_reg;
                                qop.push_en       = 1'b1;
                                qop.push_lvl      = fbq_pkg::LVL_ONE;
                                res_next.accepted = 1'b1;
                            end
                        end
                        fbq_pkg::OP_TICK: begin
                            if (s_data.tick_count != 5'd0) begin
                                if (32'(s_data.tick_count) > 32'(MAX_TICKS)) begin
                                    ticks_next = TW'(MAX_TICKS);
                                end else begin
                                    ticks_next = TW'(s_data.tick_count);
                                end
                                state_next = fbq_pkg::ST_EVAL;
                            end
                        end
                        fbq_pkg::OP_BOOST: begin
                            moved_next = '0;
                            state_next = fbq_pkg::ST_BRD;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Retire a finished job or demote one whose quantum is spent.
            fbq_pkg::ST_EVAL: begin
                res_next   = '0;
                state_next = fbq_pkg::ST_SEL;
                if (run_vld_reg && run_job_reg.remaining == 16'd0) begin
                    res_next.finished_valid = 1'b1;
                    res_next.finished_id    = run_job_reg.id;
                    res_next.finish_time    = clk_cnt_reg;
                    res_next.turnaround     = ta;
                    res_next.waiting_time   = ta - {16'd0, run_job_reg.burst};
                    run_vld_next            = 1'b0;
                end else if (run_vld_reg
                             && ((cur_lvl_reg == 2'd1
                                  && run_job_reg.used >= quantum_l1_reg)
                                 || (cur_lvl_reg == 2'd2
                                  && run_job_reg.used >= quantum_l2_reg))) begin
                    ram_we         = 1'b1;
                    ram_wdata.used = 16'd0;
                    if (cur_lvl_reg == 2'd1) begin
                        ram_waddr    = {fbq_pkg::LVL_TWO, tail[1]};
                        qop.push_lvl = fbq_pkg::LVL_TWO;
                    end else begin
                        ram_waddr    = {fbq_pkg::LVL_THREE, tail[2]};
                        qop.push_lvl = fbq_pkg::LVL_THREE;
                    end
                    qop.push_en  = 1'b1;
                    run_vld_next = 1'b0;
                end
            end

            // Fill an idle slot, or preempt a lower level for a level-one job.
            fbq_pkg::ST_SEL: begin
                state_next = fbq_pkg::ST_RUN;
                if (!run_vld_reg) begin
                    if (cnt[0] != '0) begin
                        qop.pop_lvl  = fbq_pkg::LVL_ONE;
                        cur_lvl_next = 2'd1;
                    end else if (cnt[1] != '0) begin
                        qop.pop_lvl  = fbq_pkg::LVL_TWO;
                        cur_lvl_next = 2'd2;
                    end else begin
                        qop.pop_lvl  = fbq_pkg::LVL_THREE;
                        cur_lvl_next = 2'd3;
                    end
                    if (cnt[0] != '0 || cnt[1] != '0 || cnt[2] != '0) begin
                        qop.pop_en = 1'b1;
                        state_next = fbq_pkg::ST_LOAD;
                    end else begin
                        cur_lvl_next = cur_lvl_reg;
                    end
                end else if ((cur_lvl_reg == 2'd2 || cur_lvl_reg == 2'd3)
                             && cnt[0] != '0) begin
                    ram_we       = 1'b1;
                    qop.push_en  = 1'b1;
                    qop.push_lvl = cur_lvl_reg - 2'd1;
                    ram_waddr    = {cur_lvl_reg - 2'd1,
                                    (cur_lvl_reg == 2'd2) ? tail[1] : tail[2]};
                    qop.pop_en   = 1'b1;
                    qop.pop_lvl  = fbq_pkg::LVL_ONE;
                    cur_lvl_next = 2'd1;
                    state_next   = fbq_pkg::ST_LOAD;
                end
                ram_raddr = {qop.pop_lvl, head[qop.pop_lvl]};
            end

            // Store read data arrives: it becomes the running job.
            fbq_pkg::ST_LOAD: begin
                run_job_next = rd_job;
                run_vld_next = 1'b1;
                state_next   = fbq_pkg::ST_RUN;
            end

            // The running job consumes one unit and the clock moves on.
            fbq_pkg::ST_RUN: begin
                if (run_vld_reg) begin
                    if (run_job_reg.remaining != 16'd0) begin
                        run_job_next.remaining = run_job_reg.remaining - 16'd1;
                    end
                    if (run_job_reg.used != 16'hFFFF) begin
                        run_job_next.used = run_job_reg.used + 16'd1;
                    end
                    res_next.running_valid = 1'b1;
                    res_next.running_id    = run_job_reg.id;
                    res_next.running_level = cur_lvl_reg;
                end
                clk_cnt_next  = clk_cnt_reg + 32'd1;
                ticks_next    = ticks_reg - TW'(1);
                res_next.last = (ticks_reg == TW'(1));
                state_next    = fbq_pkg::ST_EMIT;
            end

            // Boost: read the head of level two, else level three.
            fbq_pkg::ST_BRD: begin
                if (cnt[1] != '0) begin
                    qop.pop_en  = 1'b1;
                    qop.pop_lvl = fbq_pkg::LVL_TWO;
                    state_next  = fbq_pkg::ST_BWR;
                end else if (cnt[2] != '0) begin
                    qop.pop_en  = 1'b1;
                    qop.pop_lvl = fbq_pkg::LVL_THREE;
                    state_next  = fbq_pkg::ST_BWR;
                end else begin
                    res_next               = '0;
                    res_next.boosted_count = moved_reg;
                    res_next.last          = 1'b1;
                    state_next             = fbq_pkg::ST_EMIT;
                end
                ram_raddr = {qop.pop_lvl, head[qop.pop_lvl]};
            end

            // Boost: append the job read to level one with a fresh quantum.
            fbq_pkg::ST_BWR: begin
                ram_we         = 1'b1;
                ram_waddr      = {fbq_pkg::LVL_ONE, tail[0]};
                ram_wdata      = rd_job;
                ram_wdata.used = 16'd0;
                qop.push_en    = 1'b1;
                qop.push_lvl   = fbq_pkg::LVL_ONE;
                moved_next     = moved_reg + 5'd1;
                state_next     = fbq_pkg::ST_BRD;
            end

            // Hand the result to the output register once it is free.
            fbq_pkg::ST_EMIT: begin
                if (out_free) begin
                    if (res_reg.last) begin
                        state_next = fbq_pkg::ST_IDLE;
                    end else begin
                        state_next = fbq_pkg::ST_EVAL;
                    end
                end
            end

            default: begin
                state_next = fbq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and scheduler state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fbq_pkg::ST_IDLE;
            run_vld_reg    <= 1'b0;
            cur_lvl_reg    <= 2'd0;
            clk_cnt_reg    <= 32'd0;
            quantum_l1_reg <= fbq_pkg::QUANTUM_L1_RST;
            quantum_l2_reg <= fbq_pkg::QUANTUM_L2_RST;
            ticks_reg      <= '0;
            moved_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            run_vld_reg <= run_vld_next;
            cur_lvl_reg <= cur_lvl_next;
            clk_cnt_reg <= clk_cnt_next;
            ticks_reg   <= ticks_next;
            moved_reg   <= moved_next;
            if (cfg_valid && cfg_index == fbq_pkg::CFG_QUANTUM_L1) begin
                quantum_l1_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == fbq_pkg::CFG_QUANTUM_L2) begin
                quantum_l2_reg <= cfg_data;
            end
            if (state_reg == fbq_pkg::ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        run_job_reg <= run_job_next;
        res_reg     <= res_next;
        if (state_reg == fbq_pkg::ST_EMIT && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    // The block never holds more than MAX_JOBS jobs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        total <= (CW+2)'(MAX_JOBS))
        else $error("job count exceeds capacity");

    // A load from the store always follows a selection that issued the read.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fbq_pkg::ST_LOAD) |-> ($past(state_reg) == fbq_pkg::ST_SEL))
        else $error("load without a preceding read");

    // A running job always carries a level between one and three.
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_vld_reg |-> (cur_lvl_reg != 2'd0))
        else $error("running job without a level");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the three-level feedback queue scheduler.
// Depends on fbq_pkg and three_level_feedback_queue_scheduler_top; a scoreboard class
// predicts every result transaction while plain tasks drive the input and configuration channels.
`timescale 1ns / 100ps

// Scoreboard: shadow copy of the scheduler and a queue of the results it predicts.
class sched_scoreboard;
    fbq_pkg::job_t      level_q[3][$];
    fbq_pkg::job_t      run_job;
    bit                 run_busy;
    logic [1:0]         run_lvl;
    logic [31:0]        sched_clock;
    logic [15:0]        quantum[2];
    fbq_pkg::out_item_t pending_results[$];
    int                 mismatches;
    int                 errors;
    int                 n_added;
    int                 n_refused;
    int                 n_retired;
    int                 n_boosts;
    int                 n_units;

    function new();
        run_busy    = 0;
        run_lvl     = fbq_pkg::LVL_ONE;
        sched_clock = '0;
        quantum[0]  = fbq_pkg::QUANTUM_L1_RST;
        quantum[1]  = fbq_pkg::QUANTUM_L2_RST;
        mismatches  = 0;
        errors      = 0;
    endfunction

    function void set_quantum(logic [1:0] idx, logic [15:0] val);
        if (idx == fbq_pkg::CFG_QUANTUM_L1) begin
            quantum[0] = val;
        end else if (idx == fbq_pkg::CFG_QUANTUM_L2) begin
            quantum[1] = val;
        end
    endfunction

    function int jobs_held();
        return level_q[0].size() + level_q[1].size() + level_q[2].size() + run_busy;
    endfunction

    // One time unit: retire, demote, select or preempt, then run.
    function void time_unit(ref fbq_pkg::out_item_t r);
        logic [31:0] ta;
        if (run_busy && run_job.remaining == 0) begin
            ta = sched_clock - run_job.arrival;
            r.finished_valid = 1'b1;
            r.finished_id    = run_job.id;
            r.finish_time    = sched_clock;
            r.turnaround     = ta;
            r.waiting_time   = ta - {16'd0, run_job.burst};
            run_busy = 0;
            n_retired++;
        end else if (run_busy && run_lvl != fbq_pkg::LVL_THREE
                     && run_job.used >= quantum[run_lvl]) begin
            run_job.used = '0;
            level_q[run_lvl + 1].push_back(run_job);
            run_busy = 0;
        end
        if (!run_busy) begin
            for (int lv = 0; lv < 3; lv++) begin
                if (!run_busy && level_q[lv].size() > 0) begin
                    run_job  = level_q[lv].pop_front();
                    run_busy = 1;
                    run_lvl  = lv[1:0];
                end
            end
        end else if (run_lvl != fbq_pkg::LVL_ONE && level_q[0].size() > 0) begin
            level_q[run_lvl].push_back(run_job);
            run_job = level_q[0].pop_front();
            run_lvl = fbq_pkg::LVL_ONE;
        end
        if (run_busy) begin
            if (run_job.remaining > 0) run_job.remaining--;
            if (run_job.used < 16'hFFFF) run_job.used++;
            r.running_valid = 1'b1;
            r.running_id    = run_job.id;
            r.running_level = run_lvl + 2'd1;
        end
        sched_clock++;
        n_units++;
    endfunction

    // Works out the results caused by one accepted input transaction.
    function void note_input(fbq_pkg::in_item_t it);
        fbq_pkg::out_item_t r;
        int                 units;
        fbq_pkg::job_t      j;
        int                 moved;
        r = '0;
        if (it.op == fbq_pkg::OP_ADD) begin
            if (it.burst_time != 0 && jobs_held() < fbq_pkg::MAX_JOBS_DEF) begin
                j.id = it.job_id;
                j.burst = it.burst_time;
                j.remaining = it.burst_time;
                j.used = '0;
                j.arrival = sched_clock;
                level_q[0].push_back(j);
                r.accepted = 1'b1;
                n_added++;
            end else begin
                n_refused++;
            end
            r.last = 1'b1;
            pending_results.push_back(r);
        end else if (it.op == fbq_pkg::OP_BOOST) begin
            moved = 0;
            for (int lv = 1; lv < 3; lv++) begin
                while (level_q[lv].size() > 0) begin
                    j = level_q[lv].pop_front();
                    j.used = '0;
                    level_q[0].push_back(j);
                    moved++;
                end
            end
            r.boosted_count = moved[4:0];
            r.last = 1'b1;
            pending_results.push_back(r);
            n_boosts++;
        end else if (it.op == fbq_pkg::OP_TICK && it.tick_count != 0) begin
            units = (it.tick_count > fbq_pkg::MAX_TICKS_DEF) ? fbq_pkg::MAX_TICKS_DEF
                                                             : it.tick_count;
            for (int k = 0; k < units; k++) begin
                r = '0;
                time_unit(r);
                r.last = (k == units - 1);
                pending_results.push_back(r);
            end
        end else begin
            r.last = 1'b1;
            pending_results.push_back(r);
        end
    endfunction

    // Compares one result transaction with the oldest prediction.
    function void check_result(fbq_pkg::out_item_t got);
        fbq_pkg::out_item_t want;
        if (pending_results.size() == 0) begin
            errors++;
            if (errors + mismatches <= 10)
                $display("Unexpected result transaction %h", got);
            return;
        end
        want = pending_results.pop_front();
        if (got.accepted !== want.accepted || got.boosted_count !== want.boosted_count
            || got.running_valid !== want.running_valid
            || got.running_id !== want.running_id
            || got.running_level !== want.running_level
            || got.finished_valid !== want.finished_valid
            || got.finished_id !== want.finished_id
            || got.finish_time !== want.finish_time
            || got.turnaround !== want.turnaround
            || got.waiting_time !== want.waiting_time || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch at %0t: expected %p, got %p", $realtime, want, got);
        end
    endfunction
endclass

module tb;
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    fbq_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    fbq_pkg::out_item_t m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    sched_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int next_id = 0;

    localparam int WATCHDOG_LIMIT = 5000;

    three_level_feedback_queue_scheduler_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Receiver side: random back-pressure and result checking.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: ends the run when no transaction moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding",
                     sb.pending_results.size());
            $display("FAIL three_level_feedback_queue_scheduler_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one input transaction and waits for its acceptance.
    task send_item(fbq_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    task write_quantum(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_quantum(idx, val);
    endtask

    // Lets the block drain before a register write or the end of the run.
    task drain();
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic fbq_pkg::in_item_t make_item(logic [1:0] op, int id, int burst,
                                                    int units);
        fbq_pkg::in_item_t it;
        it.op = op;
        it.job_id = id[15:0];
        it.burst_time = burst[15:0];
        it.tick_count = units[4:0];
        return it;
    endfunction

    // Random transaction: mostly adds with short bursts and advances, some boosts.
    function automatic fbq_pkg::in_item_t random_item();
        int sel;
        int burst;
        sel = $urandom_range(99);
        if (sel < 40) begin
            case ($urandom_range(19))
                0:       burst = 0;
                1:       burst = $urandom_range(65535);
                2:       burst = $urandom_range(300, 40);
                default: burst = $urandom_range(12, 1);
            endcase
            return make_item(fbq_pkg::OP_ADD, $urandom_range(65535), burst,
                             $urandom_range(31));
        end else if (sel < 87) begin
            return make_item(fbq_pkg::OP_TICK, $urandom_range(65535), $urandom_range(65535),
                             ($urandom_range(4) == 0) ? 16 : $urandom_range(8, 1));
        end
        return make_item(fbq_pkg::OP_BOOST, $urandom_range(65535), $urandom_range(65535),
                         $urandom_range(31));
    endfunction

    initial begin
        int idle_set[4][2];
        logic [15:0] q1_set[4];
        logic [15:0] q2_set[4];
        idle_set = '{'{0, 0}, '{57, 0}, '{0, 57}, '{29, 29}};
        q1_set = '{16'd2, 16'd1, 16'd65535, 16'd3};
        q2_set = '{16'd4, 16'd1, 16'd65535, 16'd7};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: refused zero burst, field extremes, full store, boosts.
        send_item(make_item(fbq_pkg::OP_ADD, 16'h1234, 0, 0));
        send_item(make_item(fbq_pkg::OP_ADD, 0, 1, 31));
        send_item(make_item(fbq_pkg::OP_ADD, 65535, 65535, 0));
        for (int k = 0; k < 14; k++) send_item(make_item(fbq_pkg::OP_ADD, 100 + k, k + 2, 5));
        send_item(make_item(fbq_pkg::OP_ADD, 999, 3, 0));
        send_item(make_item(fbq_pkg::OP_TICK, 0, 0, 16));
        send_item(make_item(fbq_pkg::OP_TICK, 0, 0, 1));
        send_item(make_item(fbq_pkg::OP_BOOST, 0, 0, 0));
        send_item(make_item(fbq_pkg::OP_TICK, 65535, 65535, 16));
        send_item(make_item(fbq_pkg::OP_BOOST, 65535, 65535, 31));
        send_item(make_item(fbq_pkg::OP_TICK, 0, 0, 16));
        drain();

        // Random phases, each with its own quanta and idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            write_quantum(fbq_pkg::CFG_QUANTUM_L1, q1_set[ph]);
            write_quantum(fbq_pkg::CFG_QUANTUM_L2, q2_set[ph]);
            send_idle_pct  = idle_set[ph][0];
            recv_stall_pct = idle_set[ph][1];
            for (int n = 0; n < 102; n++) send_item(random_item());
            drain();
        end
        recv_stall_pct = 0;

        sb.errors += sb.pending_results.size();
        $display("Covered %0d accepted adds, %0d refused adds, %0d boosts, %0d time units,",
                 sb.n_added, sb.n_refused, sb.n_boosts, sb.n_units);
        $display("and %0d retired jobs across four quanta settings and idling patterns.",
                 sb.n_retired);
        if (sb.errors == 0 && sb.mismatches == 0) begin
            $display("PASS three_level_feedback_queue_scheduler_top");
        end else begin
            $display("%0d mismatches, %0d other errors", sb.mismatches, sb.errors);
            $display("FAIL three_level_feedback_queue_scheduler_top");
        end
        $finish;
    end
endmodule

### files.f
rtl/fbq_pkg.sv
rtl/fbq_ram.sv
rtl/fbq_qptr.sv
rtl/three_level_feedback_queue_scheduler_top.sv
tb/tb.sv
